[src/md5_pkg.sv]
`default_nettype none

package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_LAST,
    OP_BYTE_LAST
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_ROUND,
    ST_ADD,
    ST_PADW,
    ST_ZERO,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_EMIT
  } state_e;

  // where the sequencer goes once a compression has been folded in
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_ZERO,
    RET_EMIT
  } ret_e;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int BlockWords = 16;
  localparam int WordAddrW  = $clog2(BlockWords);

  localparam logic [1:0] LastWordNum = 2'd3;
  localparam logic [5:0] LastRound   = 6'd63;
  localparam logic [7:0] PadByte     = 8'h80;

  // word index of the length field and the zero-fill limits
  localparam logic [WordAddrW-1:0] LenLoWord = WordAddrW'(14);
  localparam logic [WordAddrW-1:0] LenHiWord = WordAddrW'(15);
  localparam logic [WordAddrW:0]   ZeroLimOne = (WordAddrW+1)'(14);
  localparam logic [WordAddrW:0]   ZeroLimTwo = (WordAddrW+1)'(16);

  function automatic logic [31:0] init_word(input logic [1:0] k);
    logic [31:0] r;
    case (k)
      2'd0:    r = 32'h67452301;
      2'd1:    r = 32'hefcdab89;
      2'd2:    r = 32'h98badcfe;
      default: r = 32'h10325476;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'hd76aa478;  6'd1:  r = 32'he8c7b756;
      6'd2:  r = 32'h242070db;  6'd3:  r = 32'hc1bdceee;
      6'd4:  r = 32'hf57c0faf;  6'd5:  r = 32'h4787c62a;
      6'd6:  r = 32'ha8304613;  6'd7:  r = 32'hfd469501;
      6'd8:  r = 32'h698098d8;  6'd9:  r = 32'h8b44f7af;
      6'd10: r = 32'hffff5bb1;  6'd11: r = 32'h895cd7be;
      6'd12: r = 32'h6b901122;  6'd13: r = 32'hfd987193;
      6'd14: r = 32'ha679438e;  6'd15: r = 32'h49b40821;
      6'd16: r = 32'hf61e2562;  6'd17: r = 32'hc040b340;
      6'd18: r = 32'h265e5a51;  6'd19: r = 32'he9b6c7aa;
      6'd20: r = 32'hd62f105d;  6'd21: r = 32'h02441453;
      6'd22: r = 32'hd8a1e681;  6'd23: r = 32'he7d3fbc8;
      6'd24: r = 32'h21e1cde6;  6'd25: r = 32'hc33707d6;
      6'd26: r = 32'hf4d50d87;  6'd27: r = 32'h455a14ed;
      6'd28: r = 32'ha9e3e905;  6'd29: r = 32'hfcefa3f8;
      6'd30: r = 32'h676f02d9;  6'd31: r = 32'h8d2a4c8a;
      6'd32: r = 32'hfffa3942;  6'd33: r = 32'h8771f681;
      6'd34: r = 32'h6d9d6122;  6'd35: r = 32'hfde5380c;
      6'd36: r = 32'ha4beea44;  6'd37: r = 32'h4bdecfa9;
      6'd38: r = 32'hf6bb4b60;  6'd39: r = 32'hbebfbc70;
      6'd40: r = 32'h289b7ec6;  6'd41: r = 32'heaa127fa;
      6'd42: r = 32'hd4ef3085;  6'd43: r = 32'h04881d05;
      6'd44: r = 32'hd9d4d039;  6'd45: r = 32'he6db99e5;
      6'd46: r = 32'h1fa27cf8;  6'd47: r = 32'hc4ac5665;
      6'd48: r = 32'hf4292244;  6'd49: r = 32'h432aff97;
      6'd50: r = 32'hab9423a7;  6'd51: r = 32'hfc93a039;
      6'd52: r = 32'h655b59c3;  6'd53: r = 32'h8f0ccc92;
      6'd54: r = 32'hffeff47d;  6'd55: r = 32'h85845dd1;
      6'd56: r = 32'h6fa87e4f;  6'd57: r = 32'hfe2ce6e0;
      6'd58: r = 32'ha3014314;  6'd59: r = 32'h4e0811a1;
      6'd60: r = 32'hf7537e82;  6'd61: r = 32'hbd3af235;
      6'd62: r = 32'h2ad7d2bb;  6'd63: r = 32'heb86d391;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
      4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
      4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
      4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // message word used by round i
  function automatic logic [WordAddrW-1:0] msg_index(input logic [5:0] i);
    logic [WordAddrW-1:0] lo;
    logic [WordAddrW-1:0] r;
    lo = i[WordAddrW-1:0];
    case (i[5:4])
      2'd0:    r = lo;
      2'd1:    r = WordAddrW'(lo * 4'd5 + 4'd1);
      2'd2:    r = WordAddrW'(lo * 4'd3 + 4'd5);
      default: r = WordAddrW'(lo * 4'd7);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_f(input logic [5:0] i, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    case (i[5:4])
      2'd0:    r = (b & c) | (~b & d);
      2'd1:    r = (b & d) | (c & ~d);
      2'd2:    r = b ^ c ^ d;
      default: r = c ^ (b | ~d);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

[src/md5_message_digest.sv]
// MD5 digest of a byte stream, one message byte per transfer.
// Bytes are taken only while idle, not during a compression. Each full 64-byte block adds a
// compression (word prefetch, 64 rounds with one shared round unit, chain add).
// Last item: padding and one compression, or padding and two when the pad byte lands past
// byte 55; then 4 digest words, one per cycle while the output queue has room. 4-deep queues.
// Reset: chain words to the MD5 initial values, bit count and queues cleared.
`default_nettype none

module md5_message_digest (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire md5_pkg::in_item_t  in_data_i,
  output logic                    empty,
  input  wire logic               pop,
  output md5_pkg::out_item_t      out_data_o
);

  logic               op_valid, op_pop, out_push, out_full;
  md5_pkg::op_t       op;
  md5_pkg::out_item_t out_item;

  md5_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  md5_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .out_push_o (out_push),
    .out_item_o (out_item),
    .out_full_i (out_full)
  );

  md5_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (out_push),
    .item_i     (out_item),
    .full_o     (out_full),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[src/md5_ram.sv]
`default_nettype none

module md5_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/md5_front.sv]
`default_nettype none

module md5_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire md5_pkg::in_item_t in_data_i,
  output logic                  op_valid_o,
  output md5_pkg::op_t          op_o,
  input  wire logic             op_pop_i
);

  md5_pkg::op_t mem_q [md5_pkg::QDepth];
  logic [md5_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [md5_pkg::QCntW-1:0] cnt_q;
  logic store, take;
  md5_pkg::op_t op_new;

  assign full       = (cnt_q == md5_pkg::QCntW'(md5_pkg::QDepth));
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = mem_q[rd_ptr_q];

  // items with neither a byte nor an end mark are dropped here
  assign store = push && !full && (in_data_i.byte_present || in_data_i.last);
  assign take  = op_pop_i && op_valid_o;

  always_comb begin
    op_new.data = in_data_i.data_byte;
    if (in_data_i.byte_present && in_data_i.last) begin
      op_new.kind = md5_pkg::OP_BYTE_LAST;
    end else if (in_data_i.byte_present) begin
      op_new.kind = md5_pkg::OP_BYTE;
    end else begin
      op_new.kind = md5_pkg::OP_LAST;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[wr_ptr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (store) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (take)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({store, take})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/md5_outq.sv]
`default_nettype none

module md5_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire md5_pkg::out_item_t item_i,
  output logic                    full_o,
  output logic                    empty,
  input  wire logic               pop,
  output md5_pkg::out_item_t      out_data_o
);

  md5_pkg::out_item_t mem_q [md5_pkg::QDepth];
  logic [md5_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [md5_pkg::QCntW-1:0] cnt_q;
  logic store, take;

  assign full_o     = (cnt_q == md5_pkg::QCntW'(md5_pkg::QDepth));
  assign empty      = (cnt_q == '0);
  assign out_data_o = mem_q[rd_ptr_q];
  assign store      = push_i && !full_o;
  assign take       = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (store) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (take)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({store, take})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/md5_core.sv]
`default_nettype none

module md5_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         op_valid_i,
  input  wire md5_pkg::op_t op_i,
  output logic              op_pop_o,
  output logic              out_push_o,
  output md5_pkg::out_item_t out_item_o,
  input  wire logic         out_full_i
);

  localparam int AW = md5_pkg::WordAddrW;

  md5_pkg::state_e state_q, state_d;
  md5_pkg::ret_e   ret_q, ret_d;
  logic [5:0]      round_q, round_d;
  logic [AW:0]     ptr_q, ptr_d;
  logic            second_q, second_d;
  logic [31:0]     word_q, word_d;
  logic [63:0]     bit_count_q, bit_count_d;
  logic [31:0]     chain_q [4];
  logic [31:0]     chain_d [4];
  logic [31:0]     a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [1:0]      emit_q, emit_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  logic [5:0]      idx;
  logic [31:0]     pad_word, round_sum, byte_word;
  logic [AW:0]     zero_lim;

  md5_ram #(.Width(32), .Depth(md5_pkg::BlockWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx       = bit_count_q[8:3];
  assign byte_word = {op_i.data, word_q[31:8]};
  assign zero_lim  = second_q ? md5_pkg::ZeroLimTwo : md5_pkg::ZeroLimOne;
  assign round_sum = a_q + md5_pkg::round_f(round_q, b_q, c_q, d_q)
                   + md5_pkg::round_k(round_q) + ram_rdata;

  // bytes gather at the top of word_q; tail bytes shift down under the pad byte
  always_comb begin
    case (idx[1:0])
      2'd0:    pad_word = {24'h0, md5_pkg::PadByte};
      2'd1:    pad_word = {16'h0, md5_pkg::PadByte, word_q[31:24]};
      2'd2:    pad_word = {8'h0, md5_pkg::PadByte, word_q[31:16]};
      default: pad_word = {md5_pkg::PadByte, word_q[31:8]};
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    round_d     = round_q;
    ptr_d       = ptr_q;
    second_d    = second_q;
    word_d      = word_q;
    bit_count_d = bit_count_q;
    chain_d     = chain_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    emit_d      = emit_q;
    op_pop_o    = 1'b0;
    out_push_o  = 1'b0;
    out_item_o.digest_word = chain_q[emit_q];
    out_item_o.word_number = emit_q;
    out_item_o.last_word   = (emit_q == md5_pkg::LastWordNum);
    ram_we      = 1'b0;
    ram_waddr   = idx[5:2];
    ram_wdata   = byte_word;
    ram_raddr   = md5_pkg::msg_index(round_q);

    case (state_q)
      md5_pkg::ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          if (op_i.kind == md5_pkg::OP_LAST) begin
            state_d = md5_pkg::ST_PADW;
          end else begin
            word_d      = byte_word;
            ram_we      = (idx[1:0] == 2'd3);
            bit_count_d = bit_count_q + 64'd8;
            if (idx == 6'h3f) begin
              ret_d   = (op_i.kind == md5_pkg::OP_BYTE_LAST) ? md5_pkg::RET_PAD
                                                             : md5_pkg::RET_IDLE;
              state_d = md5_pkg::ST_PRE;
            end else if (op_i.kind == md5_pkg::OP_BYTE_LAST) begin
              state_d = md5_pkg::ST_PADW;
            end
          end
        end
      end
      md5_pkg::ST_PRE: begin
        ram_raddr = md5_pkg::msg_index(6'd0);
        a_d       = chain_q[0];
        b_d       = chain_q[1];
        c_d       = chain_q[2];
        d_d       = chain_q[3];
        round_d   = 6'd0;
        state_d   = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        // fetch the word for the next round while this one computes
        ram_raddr = md5_pkg::msg_index(round_q + 6'd1);
        a_d       = d_q;
        d_d       = c_q;
        c_d       = b_q;
        b_d       = b_q + md5_pkg::rotl(round_sum, md5_pkg::rot_amount(round_q));
        round_d   = round_q + 6'd1;
        if (round_q == md5_pkg::LastRound) begin
          state_d = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        case (ret_q)
          md5_pkg::RET_IDLE: state_d = md5_pkg::ST_IDLE;
          md5_pkg::RET_PAD:  state_d = md5_pkg::ST_PADW;
          md5_pkg::RET_ZERO: begin
            ptr_d    = '0;
            second_d = 1'b0;
            state_d  = md5_pkg::ST_ZERO;
          end
          default: begin
            emit_d  = 2'd0;
            state_d = md5_pkg::ST_EMIT;
          end
        endcase
      end
      md5_pkg::ST_PADW: begin
        ram_we    = 1'b1;
        ram_wdata = pad_word;
        ptr_d     = {1'b0, idx[5:2]} + 1'b1;
        // pad byte lands past the length slot: the length goes in an extra block
        second_d  = (idx[5:3] == 3'b111);
        state_d   = md5_pkg::ST_ZERO;
      end
      md5_pkg::ST_ZERO: begin
        if (ptr_q == zero_lim) begin
          if (second_q) begin
            ret_d   = md5_pkg::RET_ZERO;
            state_d = md5_pkg::ST_PRE;
          end else begin
            state_d = md5_pkg::ST_LEN_LO;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q[AW-1:0];
          ram_wdata = '0;
          ptr_d     = ptr_q + 1'b1;
        end
      end
      md5_pkg::ST_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = md5_pkg::LenLoWord;
        ram_wdata = bit_count_q[31:0];
        state_d   = md5_pkg::ST_LEN_HI;
      end
      md5_pkg::ST_LEN_HI: begin
        ram_we    = 1'b1;
        ram_waddr = md5_pkg::LenHiWord;
        ram_wdata = bit_count_q[63:32];
        ret_d     = md5_pkg::RET_EMIT;
        state_d   = md5_pkg::ST_PRE;
      end
      md5_pkg::ST_EMIT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          emit_d     = emit_q + 2'd1;
          if (emit_q == md5_pkg::LastWordNum) begin
            for (int k = 0; k < 4; k++) begin
              chain_d[k] = md5_pkg::init_word(2'(k));
            end
            bit_count_d = '0;
            state_d     = md5_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5_pkg::ST_IDLE;
      ret_q       <= md5_pkg::RET_IDLE;
      round_q     <= '0;
      ptr_q       <= '0;
      second_q    <= 1'b0;
      emit_q      <= '0;
      bit_count_q <= '0;
      for (int k = 0; k < 4; k++) begin
        chain_q[k] <= md5_pkg::init_word(2'(k));
      end
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      round_q     <= round_d;
      ptr_q       <= ptr_d;
      second_q    <= second_d;
      emit_q      <= emit_d;
      bit_count_q <= bit_count_d;
      chain_q     <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
  end

endmodule

`default_nettype wire

[src/md5_checker.sv]
`default_nettype none

module md5_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire md5_pkg::out_item_t out_data_o
);

  logic [1:0] exp_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_num_q <= '0;
    end else if (pop && !empty) begin
      exp_num_q <= exp_num_q + 2'd1;
    end
  end

  // digest words leave in order A, B, C, D
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_data_o.word_number == exp_num_q)
    else $error("digest word out of order");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_data_o.last_word == (out_data_o.word_number == md5_pkg::LastWordNum))
    else $error("last_word flag mismatch");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed");

endmodule

bind md5_message_digest md5_checker u_checker (.*);

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandItems  = 350;
  localparam int unsigned LengthSlot = 56;
  localparam int unsigned VecCount   = 13;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         ends;
    logic         known;
    logic [127:0] digest;  // A in the top word
  } vector_row_t;

  // directed sequence; digests typed in for the well-known strings
  vector_row_t vectors [0:VecCount-1] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec},  // ""
    '{8'h00, 1'b0, 1'b0, 1'b0, 128'h0},                                   // ignored
    '{8'h61, 1'b1, 1'b1, 1'b1, 128'hb975c10c_a8b6f1c0_e299c331_61267769},  // "a"
    '{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 128'h0},                                   // ignored
    '{8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h63, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 128'h98500190_b04fd23c_7d3f96d6_727fe128},  // "abc"
    '{8'h00, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 128'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 128'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec}
  };

  logic [31:0] sine_k [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  int unsigned shift_amt [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  // lengths around the padding and block boundaries
  int unsigned boundary_len [0:5] = '{55, 56, 57, 63, 64, 65};
  int unsigned long_len [0:3]     = '{119, 120, 127, 128};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  md5_pkg::in_item_t  in_data = '0;
  md5_pkg::out_item_t out_data;

  // predictor state
  logic [31:0]        hash_state [0:3];
  logic [7:0]         msg_block [0:63];
  logic [63:0]        msg_bits;
  md5_pkg::out_item_t digest_q [$];

  md5_pkg::out_item_t want;
  int unsigned accepted_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned pop_hold = 0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;

  md5_message_digest u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  always #2 clk_i = ~clk_i;

  function automatic void restart_message();
    hash_state[0] = 32'h67452301;
    hash_state[1] = 32'hefcdab89;
    hash_state[2] = 32'h98badcfe;
    hash_state[3] = 32'h10325476;
    msg_bits = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [0:15];
    logic [31:0] a, b, c, d, f, t, sum;
    int unsigned g, s;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = shift_amt[(i / 16) * 4 + i % 4];
      sum = a + f + sine_k[i] + w[g];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    hash_state[0] = hash_state[0] + a;
    hash_state[1] = hash_state[1] + b;
    hash_state[2] = hash_state[2] + c;
    hash_state[3] = hash_state[3] + d;
  endfunction

  // takes one accepted item; on the end of a message queues the four digest words
  function automatic void absorb_item(input md5_pkg::in_item_t it);
    int unsigned pos;
    md5_pkg::out_item_t word;
    if (it.byte_present) begin
      pos = 32'(msg_bits[8:3]);
      msg_block[pos] = it.data_byte;
      msg_bits = msg_bits + 64'd8;
      if (pos == 63) fold_block();
    end
    if (!it.last) return;
    pos = 32'(msg_bits[8:3]);
    msg_block[pos] = md5_pkg::PadByte;
    pos = pos + 1;
    // no room for the length: pad out this block and start another
    if (pos > LengthSlot) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos = pos + 1;
      end
      fold_block();
      pos = 0;
    end
    while (pos < LengthSlot) begin
      msg_block[pos] = 8'h00;
      pos = pos + 1;
    end
    for (int k = 0; k < 8; k++) msg_block[LengthSlot + k] = msg_bits[8*k +: 8];
    fold_block();
    for (int k = 0; k < 4; k++) begin
      word.digest_word = hash_state[k];
      word.word_number = 2'(k);
      word.last_word   = (k == 3);
      digest_q.insert(digest_q.size(), word);
    end
    restart_message();
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] exp_val);
    $display("mismatch %s: got %h, want %h at %0t", what, got, exp_val, $time);
    mismatches++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // call right after a rising edge; returns right after the edge of the transfer
  task automatic push_item(input md5_pkg::in_item_t it);
    int unsigned gap;
    gap = 0;
    if (!calm_tx && $urandom_range(0, 3) == 0) gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // one edge first so the monitor has taken the last transfer
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // result side
  always @(posedge clk_i) begin
    if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      pop <= (pop_hold == 1);
    end else if (pop && !empty && !calm_rx && $urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      pop_hold <= idle_len();
    end else begin
      pop <= 1'b1;
    end
  end

  // transfer monitor: check results, predict on accepted items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          flag_error("unexpected digest word", out_data.digest_word, 32'h0);
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word)
            flag_error("digest_word", out_data.digest_word, want.digest_word);
          if (out_data.word_number !== want.word_number)
            flag_error("word_number", 32'(out_data.word_number), 32'(want.word_number));
          if (out_data.last_word !== want.last_word)
            flag_error("last_word", 32'(out_data.last_word), 32'(want.last_word));
        end
      end
      if (push && !full) begin
        absorb_item(in_data);
        // known strings: the typed digest replaces the predicted one
        if (accepted_count < VecCount && vectors[accepted_count].known) begin
          for (int k = 0; k < 4; k++) begin
            want = digest_q[digest_q.size() - 4 + k];
            want.digest_word = vectors[accepted_count].digest[(3 - k) * 32 +: 32];
            digest_q[digest_q.size() - 4 + k] = want;
          end
        end
        accepted_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned r, len, items_sent;
    bit tail_on_byte;
    md5_pkg::in_item_t it;
    items_sent = 0;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    restart_message();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int v = 0; v < VecCount; v++) begin
      it.data_byte    = vectors[v].data;
      it.byte_present = vectors[v].present;
      it.last         = vectors[v].ends;
      push_item(it);
    end
    wait_drained();

    while (items_sent < RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 60) len = $urandom_range(0, 8);
      else if (r < 78) len = $urandom_range(9, 54);
      else if (r < 90) len = boundary_len[$urandom_range(0, 5)];
      else if (r < 97) len = $urandom_range(66, 118);
      else len = long_len[$urandom_range(0, 3)];
      calm_tx = ($urandom_range(0, 9) < 3);
      calm_rx = ($urandom_range(0, 9) < 3);
      tail_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        // stray item with no byte, to be ignored
        if ($urandom_range(0, 15) == 0) begin
          it.data_byte    = 8'($urandom);
          it.byte_present = 1'b0;
          it.last         = 1'b0;
          push_item(it);
        end
        it.data_byte    = 8'($urandom);
        it.byte_present = 1'b1;
        it.last         = tail_on_byte && (i == len - 1);
        push_item(it);
        items_sent++;
      end
      if (!tail_on_byte) begin
        it.data_byte    = 8'($urandom);
        it.byte_present = 1'b0;
        it.last         = 1'b1;
        push_item(it);
        items_sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
